### design/lsa_pkg.sv
// Package for the LED strip animation sequencer: stream widths, command,
// result and register codes, strip sizes and the sequencer state type.
// It has no dependencies.
`timescale 1ns / 1ps

package lsa_pkg;

  // Strip sizes, in pixels (2 to 256 each).
  localparam int STRIP_ONE_LEDS = 64;
  localparam int STRIP_TWO_LEDS = 64;

  // Derived pixel positions, all kept modulo 256.
  localparam logic [7:0] ONE_LAST = 8'(STRIP_ONE_LEDS - 1);
  localparam logic [7:0] TWO_LAST = 8'(STRIP_TWO_LEDS - 1);
  localparam logic [7:0] ONE_HALF = 8'(STRIP_ONE_LEDS / 2);

  // Stream widths.
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_RED      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_GREEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_BLUE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_CLAMP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_DELAY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_DELAY   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_AMP     = 3'd7;

  // Input commands.
  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_ON     = 3'd1;
  localparam logic [2:0] MODE_OFF    = 3'd2;
  localparam logic [2:0] MODE_STRIKE = 3'd3;
  localparam logic [2:0] MODE_SWING  = 3'd4;
  localparam logic [2:0] MODE_PULSE  = 3'd5;

  // Result kinds and strip numbers.
  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_FILL  = 2'd1;
  localparam logic [1:0] KIND_SHOW  = 2'd2;
  localparam logic [1:0] STRIP_NONE = 2'd0;
  localparam logic [1:0] STRIP_ONE  = 2'd1;
  localparam logic [1:0] STRIP_TWO  = 2'd2;

  // Timing and arithmetic constants.
  localparam logic [31:0] FLASH_HOLD_MS = 32'd300;
  localparam logic [8:0]  WEIGHT_ONE    = 9'd256;
  // ceil(2^30 / 1023): floor(x * RECIP_1023 / 2^30) == floor(x / 1023) for x < 2^20.
  localparam logic signed [21:0] RECIP_1023 = 22'sd1049602;
  localparam int                 RECIP_SHIFT = 30;
  localparam logic signed [27:0] ROUND_HALF = 28'sd128;
  localparam logic signed [15:0] CLAMP_LO   = -16'sd3840;  // -15.0 in Q8.8
  localparam logic signed [15:0] CLAMP_HI   = 16'sd1280;   // 5.0 in Q8.8

  // Flash colours.
  localparam logic [7:0] STRIKE_R = 8'd255;
  localparam logic [7:0] STRIKE_G = 8'd201;
  localparam logic [7:0] STRIKE_B = 8'd0;
  localparam logic [7:0] SWING_C  = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Q,
    ST_MUL_OLD,
    ST_MUL_R,
    ST_FINISH,
    ST_COLOR,
    ST_EMIT
  } state_e;

endpackage

### design/led_strip_animation_sequencer.sv
// Top level of the LED strip animation sequencer: command decode, timers,
// a shared multiplier for the pulse filter and the result output register.
// Depends on lsa_pkg.
`timescale 1ns / 1ps

// The block takes one command or time tick per input beat and answers with
// zero to five result beats. Commands that start the turn-on or turn-off
// animation produce nothing; strike and swing produce one fill beat at once.
// A tick produces either one animation frame (four pixel writes and a show)
// or the fill that restores the base colour after a flash. A pulse check
// produces one fill with the base colour shifted by a smoothed random offset.
// Timing: the input is ready only in the idle state. A frame gives one
// result beat per cycle while the output is not stalled. A pulse check
// runs its filter as four products in a row through one 22 by 22 bit
// signed multiplier, then rounds, saturates and converts the offset to
// colours. The output register lets a new item be taken while the last
// result of the previous one still waits. Configuration writes are taken
// at any time but must only be made while no item is in progress.
module led_strip_animation_sequencer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // now_ms [31:0], random_value [41:32], zero [47:42]
  input  logic [lsa_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // mode [2:0]
  input  logic [lsa_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // strip [1:0], pixel_index [9:2], red [17:10], green [25:18], blue [33:26],
  // zero [39:34]
  output logic [lsa_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // kind [1:0]
  output logic [lsa_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
  output logic                               m_axis_tlast,
  // Configuration writes.
  input  logic                               cfg_we_i,
  input  logic [lsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lsa_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import lsa_pkg::*;

  // Configuration registers.
  logic [7:0]  base_red_q, base_green_q, base_blue_q;
  logic        blue_clamp_q;
  logic [8:0]  smooth_weight_q;
  logic [15:0] frame_delay_q, pulse_delay_q;
  logic [7:0]  pulse_amp_q;

  // Animation state.
  state_e             state_q, state_d;
  logic               on_active_q, off_active_q, strike_active_q, swing_active_q;
  logic [31:0]        frame_timer_q, pulse_timer_q;
  logic [7:0]         frame_counter_q;
  logic signed [15:0] pulse_offset_q;

  // Pulse filter datapath.
  logic [9:0]         rnd_q;
  logic signed [43:0] mul_q;
  logic signed [25:0] acc_q;
  logic signed [9:0]  r_q;
  logic signed [21:0] mul_a, mul_b;
  logic signed [43:0] product;
  logic [8:0]         w_eff, w_comp;
  logic [8:0]         quot;
  logic signed [27:0] filt_sum;
  logic signed [19:0] filt_v;
  logic signed [15:0] offset_new;

  // The job that the emit state plays out.
  logic       job_frame_q;
  logic [7:0] job_r_q, job_g_q, job_b_q;
  logic [7:0] job_c_q, job_right2_q;
  logic [2:0] beat_q;

  // Output register.
  logic        out_valid_q;
  logic [1:0]  out_kind_q, out_strip_q;
  logic [7:0]  out_idx_q, out_r_q, out_g_q, out_b_q;
  logic        out_last_q;

  // Input decode.
  logic        in_accept;
  logic [2:0]  in_mode;
  logic [31:0] in_now;
  logic [9:0]  in_rnd;
  logic [31:0] el_frame, el_pulse;
  logic        anim_busy, flash_busy;
  logic        frame_go, flash_go, pulse_go, fill_cmd;

  // Emit control.
  logic        out_load;
  logic        beat_last;
  logic [1:0]  beat_kind, beat_strip;
  logic [7:0]  beat_idx, beat_r, beat_g, beat_b;

  function automatic logic [7:0] chan(input logic [7:0] base,
                                      input logic signed [15:0] off);
    logic signed [9:0] s;
    s = $signed({2'b00, base}) + $signed({{2{off[15]}}, off[15:8]});
    if (s < 0) begin
      return 8'd0;
    end else if (s > 10'sd255) begin
      return 8'd255;
    end else begin
      return s[7:0];
    end
  endfunction

  assign in_mode   = s_axis_tuser;
  assign in_now    = s_axis_tdata[31:0];
  assign in_rnd    = s_axis_tdata[41:32];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign el_frame   = in_now - frame_timer_q;
  assign el_pulse   = in_now - pulse_timer_q;
  assign anim_busy  = on_active_q || off_active_q;
  assign flash_busy = strike_active_q || swing_active_q;

  // A frame needs elapsed time strictly above the frame delay; a flash ends
  // strictly after its hold time; a pulse update needs at least its delay.
  assign frame_go = (in_mode == MODE_TICK) && anim_busy && (el_frame > {16'd0, frame_delay_q});
  assign flash_go = (in_mode == MODE_TICK) && !anim_busy && flash_busy &&
                    (el_frame > FLASH_HOLD_MS);
  assign pulse_go = (in_mode == MODE_PULSE) && (pulse_amp_q != 8'd0) && !anim_busy &&
                    !flash_busy && (el_pulse >= {16'd0, pulse_delay_q});
  assign fill_cmd = (in_mode == MODE_STRIKE) || (in_mode == MODE_SWING);

  // Smoothing weights above one are treated as one.
  assign w_eff  = (smooth_weight_q > WEIGHT_ONE) ? WEIGHT_ONE : smooth_weight_q;
  assign w_comp = WEIGHT_ONE - w_eff;
  assign quot   = mul_q[RECIP_SHIFT+8:RECIP_SHIFT];

  // Shared multiplier, registered every cycle.
  assign product = mul_a * mul_b;

  // Filter tail: add the two weighted terms, round, floor-divide by 256,
  // saturate to 16 bits and apply the blue clamp when enabled.
  always_comb begin
    filt_sum = 28'(acc_q) + 28'($signed({mul_q[17:0], 8'b0})) + ROUND_HALF;
    filt_v   = 20'(filt_sum >>> 8);
    if (filt_v > 20'sd32767) begin
      offset_new = 16'sh7fff;
    end else if (filt_v < -20'sd32768) begin
      offset_new = 16'sh8000;
    end else begin
      offset_new = filt_v[15:0];
    end
    if (blue_clamp_q) begin
      if (offset_new < CLAMP_LO) begin
        offset_new = CLAMP_LO;
      end else if (offset_new > CLAMP_HI) begin
        offset_new = CLAMP_HI;
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (pulse_go) begin
            state_d = ST_MUL_X;
          end else if (frame_go || flash_go || fill_cmd) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_MUL_X:   state_d = ST_MUL_Q;
      ST_MUL_Q:   state_d = ST_MUL_OLD;
      ST_MUL_OLD: state_d = ST_MUL_R;
      ST_MUL_R:   state_d = ST_FINISH;
      ST_FINISH:  state_d = ST_COLOR;
      ST_COLOR:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_load && beat_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs: handshake, multiplier operands, output load strobe.
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_MUL_X: begin
        // random_value * 2A
        mul_a = $signed({12'd0, rnd_q});
        mul_b = $signed({13'd0, pulse_amp_q, 1'b0});
      end
      ST_MUL_Q: begin
        // Division by 1023 through the reciprocal.
        mul_a = $signed({2'd0, mul_q[19:0]});
        mul_b = RECIP_1023;
      end
      ST_MUL_OLD: begin
        mul_a = 22'(pulse_offset_q);
        mul_b = $signed({13'd0, w_eff});
      end
      ST_MUL_R: begin
        mul_a = 22'(r_q);
        mul_b = $signed({13'd0, w_comp});
      end
      ST_EMIT: out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  // Content of the current result beat.
  always_comb begin
    beat_kind  = KIND_FILL;
    beat_strip = STRIP_NONE;
    beat_idx   = 8'd0;
    beat_r     = job_r_q;
    beat_g     = job_g_q;
    beat_b     = job_b_q;
    beat_last  = 1'b1;
    if (job_frame_q) begin
      beat_kind = KIND_PIXEL;
      beat_last = 1'b0;
      case (beat_q)
        3'd0: begin
          beat_strip = STRIP_ONE;
          beat_idx   = job_c_q;
        end
        3'd1: begin
          beat_strip = STRIP_ONE;
          beat_idx   = ONE_LAST - job_c_q;
        end
        3'd2: begin
          beat_strip = STRIP_TWO;
          beat_idx   = job_c_q;
        end
        3'd3: begin
          beat_strip = STRIP_TWO;
          beat_idx   = job_right2_q;
        end
        default: begin
          beat_kind = KIND_SHOW;
          beat_r    = 8'd0;
          beat_g    = 8'd0;
          beat_b    = 8'd0;
          beat_last = 1'b1;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      base_red_q      <= 8'd255;
      base_green_q    <= 8'd0;
      base_blue_q     <= 8'd0;
      blue_clamp_q    <= 1'b0;
      smooth_weight_q <= 9'd230;
      frame_delay_q   <= 16'd30;
      pulse_delay_q   <= 16'd50;
      pulse_amp_q     <= 8'd10;
      on_active_q     <= 1'b0;
      off_active_q    <= 1'b0;
      strike_active_q <= 1'b0;
      swing_active_q  <= 1'b0;
      frame_timer_q   <= '0;
      frame_counter_q <= '0;
      pulse_timer_q   <= '0;
      pulse_offset_q  <= '0;
      beat_q          <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BASE_RED:      base_red_q      <= cfg_data_i[7:0];
          REG_BASE_GREEN:    base_green_q    <= cfg_data_i[7:0];
          REG_BASE_BLUE:     base_blue_q     <= cfg_data_i[7:0];
          REG_BLUE_CLAMP:    blue_clamp_q    <= cfg_data_i[0];
          REG_SMOOTH_WEIGHT: smooth_weight_q <= cfg_data_i[8:0];
          REG_FRAME_DELAY:   frame_delay_q   <= cfg_data_i;
          REG_PULSE_DELAY:   pulse_delay_q   <= cfg_data_i;
          REG_PULSE_AMP:     pulse_amp_q     <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (in_accept) begin
        beat_q <= '0;
        case (in_mode)
          MODE_ON: begin
            on_active_q     <= 1'b1;
            frame_counter_q <= '0;
            frame_timer_q   <= in_now;
          end
          MODE_OFF: begin
            off_active_q    <= 1'b1;
            frame_counter_q <= ONE_HALF - 8'd1;
            frame_timer_q   <= in_now;
          end
          MODE_STRIKE: begin
            strike_active_q <= 1'b1;
            frame_timer_q   <= in_now;
          end
          MODE_SWING: begin
            swing_active_q <= 1'b1;
            frame_timer_q  <= in_now;
          end
          MODE_TICK: begin
            if (frame_go) begin
              frame_timer_q <= in_now;
              // Turn-on wins when both animations are flagged.
              if (on_active_q) begin
                if (frame_counter_q + 8'd1 >= ONE_HALF) begin
                  frame_counter_q <= '0;
                  on_active_q     <= 1'b0;
                end else begin
                  frame_counter_q <= frame_counter_q + 8'd1;
                end
              end else if (frame_counter_q == 8'd0) begin
                off_active_q <= 1'b0;
              end else begin
                frame_counter_q <= frame_counter_q - 8'd1;
              end
            end else if (flash_go) begin
              frame_timer_q <= in_now;
              if (strike_active_q) begin
                strike_active_q <= 1'b0;
              end else begin
                swing_active_q <= 1'b0;
              end
            end
          end
          MODE_PULSE: begin
            if (pulse_go) begin
              pulse_timer_q <= in_now;
            end
          end
          default: ;
        endcase
      end

      if (state_q == ST_FINISH) begin
        pulse_offset_q <= offset_new;
      end

      if (out_load) begin
        beat_q <= beat_q + 3'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath and payload registers.
  always_ff @(posedge clk_i) begin
    mul_q <= product;
    if (state_q == ST_MUL_OLD) begin
      r_q <= $signed({1'b0, quot}) - $signed({2'b00, pulse_amp_q});
    end
    if (state_q == ST_MUL_R) begin
      acc_q <= mul_q[25:0];
    end

    if (in_accept) begin
      rnd_q        <= in_rnd;
      job_frame_q  <= frame_go;
      job_c_q      <= frame_counter_q;
      job_right2_q <= on_active_q ? (ONE_LAST - frame_counter_q)
                                  : (TWO_LAST - frame_counter_q);
      if (frame_go && !on_active_q) begin
        job_r_q <= 8'd0;
        job_g_q <= 8'd0;
        job_b_q <= 8'd0;
      end else if (in_mode == MODE_STRIKE) begin
        job_r_q <= STRIKE_R;
        job_g_q <= STRIKE_G;
        job_b_q <= STRIKE_B;
      end else if (in_mode == MODE_SWING) begin
        job_r_q <= SWING_C;
        job_g_q <= SWING_C;
        job_b_q <= SWING_C;
      end else begin
        job_r_q <= base_red_q;
        job_g_q <= base_green_q;
        job_b_q <= base_blue_q;
      end
    end

    if (state_q == ST_COLOR) begin
      job_r_q <= chan(base_red_q, pulse_offset_q);
      job_g_q <= chan(base_green_q, pulse_offset_q);
      job_b_q <= chan(base_blue_q, pulse_offset_q);
    end

    if (out_load) begin
      out_kind_q  <= beat_kind;
      out_strip_q <= beat_strip;
      out_idx_q   <= beat_idx;
      out_r_q     <= beat_r;
      out_g_q     <= beat_g;
      out_b_q     <= beat_b;
      out_last_q  <= beat_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {6'd0, out_b_q, out_g_q, out_r_q, out_idx_q, out_strip_q};

  // The turn-on counter stays below half the first strip while it runs.
  a_on_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    on_active_q |-> (frame_counter_q < ONE_HALF))
    else $error("turn-on frame counter out of range");

  // A new result beat only appears out of the emit state.
  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT))
    else $error("result beat loaded outside the emit state");

  // A frame has five beats; the beat counter never runs past the show.
  a_beat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (beat_q <= 3'd4))
    else $error("beat counter ran past the last beat");

  // In blue clamp mode the stored offset is within the clamp window.
  a_blue_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COLOR && blue_clamp_q) |->
      (pulse_offset_q >= CLAMP_LO && pulse_offset_q <= CLAMP_HI))
    else $error("pulse offset outside the blue clamp window");

endmodule

### dv/tb_led_strip_animation_sequencer.sv
// Self-checking testbench for the LED strip animation sequencer.
// Drives command beats, predicts every result beat and checks them in order.
// Depends on lsa_pkg and the led_strip_animation_sequencer top level.
`timescale 1ns / 1ps

// How the bench works:
// - An initial block fills a backlog of command beats: a short directed
//   sequence first, then six phases of random but mostly well-formed
//   animation traffic, each phase under its own register setting.
// - A driver on the falling edge offers the backlog on the input stream with
//   a random gap after every beat, with calm stretches.
// - A receiver on the falling edge toggles tready with random stalls, and
//   once holds it low for a long stretch so the block backs up.
// - A monitor on the rising edge runs the behavioral predictor on every
//   accepted command beat and compares every accepted result beat, field by
//   field, against the oldest predicted beat.
// - The stimulus generator keeps its own planning copy of the animation
//   state, advanced by the same predictor, so that it knows which commands
//   reach deep into the behavior (ticks during animations, pulse checks
//   while idle, and so on).
module tb_led_strip_animation_sequencer;
  import lsa_pkg::*;

  // Modes that the block ignores.
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 16;    // settle time after the last result
  localparam int STALL_LIMIT  = 2000;  // cycles without any beat
  localparam int PHASE_CMDS   = 63;    // counted commands per random phase

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] now_ms;
    logic [9:0]  rnd;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] strip;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } led_write_t;

  typedef struct packed {
    logic               lighting_on;
    logic               dimming_on;
    logic               strike_on;
    logic               swing_on;
    logic [31:0]        frame_timer;
    logic [7:0]         frame_counter;
    logic [31:0]        pulse_timer;
    logic signed [15:0] pulse_offset;
  } anim_state_t;

  typedef struct {
    anim_state_t st;
    int          n;
    led_write_t  w[5];
  } step_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // now_ms [31:0], random_value [41:32]
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // mode [2:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // strip, pixel_index, red, green, blue
  logic [OUT_TUSER_W-1:0] m_axis_tuser;  // kind [1:0]
  logic                   m_axis_tlast;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  // Register shadow, starting from the reset values.
  logic [7:0]  cfg_base_red    = 8'd255;
  logic [7:0]  cfg_base_green  = 8'd0;
  logic [7:0]  cfg_base_blue   = 8'd0;
  logic        cfg_blue_clamp  = 1'b0;
  logic [8:0]  cfg_weight      = 9'd230;
  logic [15:0] cfg_frame_delay = 16'd30;
  logic [15:0] cfg_pulse_delay = 16'd50;
  logic [7:0]  cfg_pulse_amp   = 8'd10;

  anim_state_t strip_state   = '0;  // advanced on accepted beats
  anim_state_t planned_state = '0;  // advanced as commands are generated
  cmd_t        cmd_backlog[$];
  led_write_t  expected_writes[$];

  logic [31:0] now_t = '0;
  int          phase_count = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  int          send_gap = 0, send_run = 0;
  bit          send_calm = 1'b0;
  int          recv_wait = 0, recv_run = 0, hold_left = 0;
  bit          recv_calm = 1'b0;
  int          holds_asked = 0, holds_given = 0;

  led_strip_animation_sequencer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic led_write_t write_beat(input logic [1:0] kind, input logic [1:0] strip,
                                            input logic [7:0] idx, input logic [7:0] red,
                                            input logic [7:0] green, input logic [7:0] blue);
    led_write_t b;
    b.kind  = kind;
    b.strip = strip;
    b.idx   = idx;
    b.red   = red;
    b.green = green;
    b.blue  = blue;
    b.last  = 1'b0;
    return b;
  endfunction

  // Base channel plus a Q8.8 offset, floored and saturated to 0..255.
  function automatic logic [7:0] shade(input logic [7:0] base, input logic signed [15:0] ofs);
    longint lvl;
    lvl = longint'(base) * 256 + longint'(ofs);
    if (lvl < 0) return 8'd0;
    lvl = lvl / 256;
    return (lvl > 255) ? 8'd255 : 8'(lvl);
  endfunction

  // One command beat in, the new state and the result beats it causes out.
  function automatic step_t animate(input anim_state_t s, input cmd_t c);
    step_t       o;
    logic [31:0] since;
    logic [31:0] since_pulse;
    logic [7:0]  col_r, col_g, col_b, far_one, far_two;
    longint      amp, draw, wgt, acc, ofs;
    o.st = s;
    o.n  = 0;
    since       = c.now_ms - s.frame_timer;
    since_pulse = c.now_ms - s.pulse_timer;
    case (c.mode)
      MODE_TICK: begin
        if (s.lighting_on || s.dimming_on) begin
          // A frame needs strictly more than the frame delay. Turn-on wins
          // over turn-off when both are running.
          if (since > 32'(cfg_frame_delay)) begin
            o.st.frame_timer = c.now_ms;
            col_r   = s.lighting_on ? cfg_base_red : 8'd0;
            col_g   = s.lighting_on ? cfg_base_green : 8'd0;
            col_b   = s.lighting_on ? cfg_base_blue : 8'd0;
            far_one = ONE_LAST - s.frame_counter;
            far_two = s.lighting_on ? far_one : TWO_LAST - s.frame_counter;
            o.w[0] = write_beat(KIND_PIXEL, STRIP_ONE, s.frame_counter, col_r, col_g, col_b);
            o.w[1] = write_beat(KIND_PIXEL, STRIP_ONE, far_one, col_r, col_g, col_b);
            o.w[2] = write_beat(KIND_PIXEL, STRIP_TWO, s.frame_counter, col_r, col_g, col_b);
            o.w[3] = write_beat(KIND_PIXEL, STRIP_TWO, far_two, col_r, col_g, col_b);
            o.w[4] = write_beat(KIND_SHOW, STRIP_NONE, 8'd0, 8'd0, 8'd0, 8'd0);
            o.n = 5;
            if (s.lighting_on) begin
              o.st.frame_counter = s.frame_counter + 8'd1;
              if (o.st.frame_counter >= ONE_HALF) begin
                o.st.frame_counter = 8'd0;
                o.st.lighting_on   = 1'b0;
              end
            end else if (s.frame_counter == 8'd0) begin
              o.st.dimming_on = 1'b0;
            end else begin
              o.st.frame_counter = s.frame_counter - 8'd1;
            end
          end
        end else if (s.strike_on || s.swing_on) begin
          // The flash is held for more than the hold time, then the base
          // colour comes back; strike is cleared before swing.
          if (since > FLASH_HOLD_MS) begin
            o.st.frame_timer = c.now_ms;
            o.w[0] = write_beat(KIND_FILL, STRIP_NONE, 8'd0,
                                cfg_base_red, cfg_base_green, cfg_base_blue);
            o.n = 1;
            if (s.strike_on) o.st.strike_on = 1'b0;
            else o.st.swing_on = 1'b0;
          end
        end
      end
      MODE_ON: begin
        o.st.lighting_on   = 1'b1;
        o.st.frame_counter = 8'd0;
        o.st.frame_timer   = c.now_ms;
      end
      MODE_OFF: begin
        o.st.dimming_on    = 1'b1;
        o.st.frame_counter = ONE_HALF - 8'd1;
        o.st.frame_timer   = c.now_ms;
      end
      MODE_STRIKE: begin
        o.w[0] = write_beat(KIND_FILL, STRIP_NONE, 8'd0, STRIKE_R, STRIKE_G, STRIKE_B);
        o.n = 1;
        o.st.frame_timer = c.now_ms;
        o.st.strike_on   = 1'b1;
      end
      MODE_SWING: begin
        o.w[0] = write_beat(KIND_FILL, STRIP_NONE, 8'd0, SWING_C, SWING_C, SWING_C);
        o.n = 1;
        o.st.frame_timer = c.now_ms;
        o.st.swing_on    = 1'b1;
      end
      MODE_PULSE: begin
        if (cfg_pulse_amp != 8'd0 && !(s.lighting_on || s.dimming_on || s.strike_on ||
            s.swing_on) && since_pulse >= 32'(cfg_pulse_delay)) begin
          o.st.pulse_timer = c.now_ms;
          // Random offset in -A..A, then a first-order smoothing in Q8.8
          // with round-half-up and a floor division.
          amp  = longint'(cfg_pulse_amp);
          draw = (longint'(c.rnd) * 2 * amp) / 1023 - amp;
          wgt  = (cfg_weight > WEIGHT_ONE) ? 256 : longint'(cfg_weight);
          acc  = longint'($signed(s.pulse_offset)) * wgt + draw * 256 * (256 - wgt) + 128;
          ofs  = acc >>> 8;
          if (ofs > 32767) ofs = 32767;
          if (ofs < -32768) ofs = -32768;
          if (cfg_blue_clamp) begin
            if (ofs < longint'(CLAMP_LO)) ofs = longint'(CLAMP_LO);
            if (ofs > longint'(CLAMP_HI)) ofs = longint'(CLAMP_HI);
          end
          o.st.pulse_offset = 16'(ofs);
          o.w[0] = write_beat(KIND_FILL, STRIP_NONE, 8'd0,
                              shade(cfg_base_red, o.st.pulse_offset),
                              shade(cfg_base_green, o.st.pulse_offset),
                              shade(cfg_base_blue, o.st.pulse_offset));
          o.n = 1;
        end
      end
      default: ;
    endcase
    if (o.n > 0) o.w[o.n-1].last = 1'b1;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Per-beat wait for either side, drawn at random, except during calm
  // stretches where the side does not idle at all.
  function automatic int draw_wait(inout int run_left, inout bit calm);
    if (run_left == 0) begin
      calm     = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(10, 40);
    end
    run_left--;
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic void queue_cmd(input logic [2:0] mode, input logic [31:0] now_ms,
                                    input logic [9:0] rnd);
    cmd_t  c;
    step_t s;
    c.mode   = mode;
    c.now_ms = now_ms;
    c.rnd    = rnd;
    s = animate(planned_state, c);
    planned_state = s.st;
    cmd_backlog.push_back(c);
    if (mode <= MODE_PULSE) phase_count++;
  endfunction

  // Broken or unusual traffic: ignored modes, and jumps of the time stamp to
  // any 32-bit value, which also exercises the wrapping elapsed time.
  function automatic void queue_noise();
    int sel;
    sel = $urandom_range(0, 2);
    now_t = $urandom();
    case (sel)
      0: queue_cmd($urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI, now_t,
                   10'($urandom_range(0, 1023)));
      1: queue_cmd(MODE_TICK, now_t, 10'($urandom_range(0, 1023)));
      default: queue_cmd(MODE_PULSE, now_t, 10'($urandom_range(0, 1023)));
    endcase
  endfunction

  // Picks the next command from what the planned state makes interesting.
  function automatic void queue_random_cmd();
    int         sel;
    logic [9:0] rnd;
    sel = $urandom_range(0, 99);
    rnd = 10'($urandom_range(0, 1023));
    if (planned_state.lighting_on || planned_state.dimming_on) begin
      if (sel < 85) begin
        // Mostly just past the frame delay, sometimes too early.
        if ($urandom_range(0, 4) == 0) now_t += 32'($urandom_range(0, cfg_frame_delay));
        else now_t += 32'(cfg_frame_delay) + 32'($urandom_range(1, 3));
        queue_cmd(MODE_TICK, now_t, rnd);
      end else if (sel < 89) begin
        queue_cmd($urandom_range(0, 1) ? MODE_STRIKE : MODE_SWING, now_t, rnd);
      end else if (sel < 93) begin
        queue_cmd(MODE_PULSE, now_t, rnd);
      end else if (sel < 97) begin
        queue_cmd($urandom_range(0, 1) ? MODE_ON : MODE_OFF, now_t, rnd);
      end else begin
        queue_noise();
      end
    end else if (planned_state.strike_on || planned_state.swing_on) begin
      if (sel < 80) begin
        now_t += 32'($urandom_range(40, 200));
        queue_cmd(MODE_TICK, now_t, rnd);
      end else if (sel < 90) begin
        queue_cmd(MODE_PULSE, now_t, rnd);
      end else if (sel < 95) begin
        queue_cmd($urandom_range(0, 1) ? MODE_STRIKE : MODE_SWING, now_t, rnd);
      end else begin
        queue_noise();
      end
    end else begin
      if (sel < 18) begin
        queue_cmd(MODE_ON, now_t, rnd);
      end else if (sel < 36) begin
        queue_cmd(MODE_OFF, now_t, rnd);
      end else if (sel < 44) begin
        queue_cmd(MODE_STRIKE, now_t, rnd);
      end else if (sel < 52) begin
        queue_cmd(MODE_SWING, now_t, rnd);
      end else if (sel < 92) begin
        // Runs of pulse checks, mostly just at the pulse delay.
        if ($urandom_range(0, 3) == 0) now_t += 32'($urandom_range(0, cfg_pulse_delay));
        else now_t += 32'(cfg_pulse_delay) + 32'($urandom_range(0, 3));
        queue_cmd(MODE_PULSE, now_t, rnd);
      end else begin
        queue_noise();
      end
    end
  endfunction

  // Register write on the configuration port, mirrored in the shadow.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_BASE_RED:      cfg_base_red    = val[7:0];
      REG_BASE_GREEN:    cfg_base_green  = val[7:0];
      REG_BASE_BLUE:     cfg_base_blue   = val[7:0];
      REG_BLUE_CLAMP:    cfg_blue_clamp  = val[0];
      REG_SMOOTH_WEIGHT: cfg_weight      = val[8:0];
      REG_FRAME_DELAY:   cfg_frame_delay = val;
      REG_PULSE_DELAY:   cfg_pulse_delay = val;
      REG_PULSE_AMP:     cfg_pulse_amp   = val[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Phases 0 and 1 sit at the extremes of every register, phase 2 disables
  // the pulse and uses a weight above one, the rest are random.
  task automatic configure_phase(input int p);
    case (p)
      0: begin
        write_reg(REG_BASE_RED, 16'd0);
        write_reg(REG_BASE_GREEN, 16'd0);
        write_reg(REG_BASE_BLUE, 16'd0);
        write_reg(REG_BLUE_CLAMP, 16'd0);
        write_reg(REG_SMOOTH_WEIGHT, 16'd0);
        write_reg(REG_FRAME_DELAY, 16'd0);
        write_reg(REG_PULSE_DELAY, 16'd0);
        write_reg(REG_PULSE_AMP, 16'd255);
      end
      1: begin
        write_reg(REG_BASE_RED, 16'd255);
        write_reg(REG_BASE_GREEN, 16'd255);
        write_reg(REG_BASE_BLUE, 16'd255);
        write_reg(REG_BLUE_CLAMP, 16'd1);
        write_reg(REG_SMOOTH_WEIGHT, 16'd256);
        write_reg(REG_FRAME_DELAY, 16'hFFFF);
        write_reg(REG_PULSE_DELAY, 16'hFFFF);
        write_reg(REG_PULSE_AMP, 16'd1);
      end
      2: begin
        write_reg(REG_BASE_RED, 16'($urandom_range(0, 255)));
        write_reg(REG_BASE_GREEN, 16'($urandom_range(0, 255)));
        write_reg(REG_BASE_BLUE, 16'($urandom_range(0, 255)));
        write_reg(REG_BLUE_CLAMP, 16'd0);
        write_reg(REG_SMOOTH_WEIGHT, 16'd511);
        write_reg(REG_FRAME_DELAY, 16'd5);
        write_reg(REG_PULSE_DELAY, 16'd10);
        write_reg(REG_PULSE_AMP, 16'd0);
      end
      default: begin
        write_reg(REG_BASE_RED, 16'($urandom_range(0, 255)));
        write_reg(REG_BASE_GREEN, 16'($urandom_range(0, 255)));
        write_reg(REG_BASE_BLUE, 16'($urandom_range(0, 255)));
        write_reg(REG_BLUE_CLAMP, 16'($urandom_range(0, 1)));
        write_reg(REG_SMOOTH_WEIGHT, 16'($urandom_range(0, 511)));
        write_reg(REG_FRAME_DELAY, 16'($urandom_range(0, 60)));
        write_reg(REG_PULSE_DELAY, 16'($urandom_range(0, 100)));
        write_reg(REG_PULSE_AMP, 16'($urandom_range(1, 255)));
      end
    endcase
  endtask

  // The sender pauses here until every predicted beat has arrived, then lets
  // the block finish any command that produces no beat. The check runs on the
  // rising edge, where the driver's last offer has settled.
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || s_axis_tvalid || expected_writes.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("result field %s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the backlog, one beat at a time, with a gap after each.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : feed
    cmd_t nxt;
    logic vld;
    vld = s_axis_tvalid;
    // A beat still waiting for tready is held unchanged.
    if (rst_ni && !(s_axis_tvalid && !in_taken)) begin
      vld = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (cmd_backlog.size() != 0) begin
        nxt = cmd_backlog.pop_front();
        s_axis_tdata <= {6'b0, nxt.rnd, nxt.now_ms};
        s_axis_tuser <= nxt.mode;
        vld = 1'b1;
        send_gap = draw_wait(send_run, send_calm);
      end
    end
    s_axis_tvalid <= vld;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls after every result beat, plus the long hold-off
  // requested by the stimulus, counted here so the sender keeps going.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : sink
    logic rdy;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (holds_given != holds_asked) begin
      holds_given++;
      hold_left = HOLD_CYCLES;
      rdy = 1'b0;
    end else begin
      if (out_taken) recv_wait = draw_wait(recv_run, recv_calm);
      else if (recv_wait > 0) recv_wait--;
      rdy = (recv_wait == 0);
    end
    m_axis_tready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks result beats first, then predicts from the command beat
  // taken at the same edge, so a beat can never be matched against its own
  // command's predictions.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : observe
    led_write_t got, want;
    cmd_t       cmd;
    step_t      res;
    in_taken  <= rst_ni && s_axis_tvalid && s_axis_tready;
    out_taken <= rst_ni && m_axis_tvalid && m_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind  = m_axis_tuser;
      got.strip = m_axis_tdata[1:0];
      got.idx   = m_axis_tdata[9:2];
      got.red   = m_axis_tdata[17:10];
      got.green = m_axis_tdata[25:18];
      got.blue  = m_axis_tdata[33:26];
      got.last  = m_axis_tlast;
      if (expected_writes.size() == 0) begin
        $error("unexpected result beat: kind %0d strip %0d pixel %0d", got.kind, got.strip,
               got.idx);
        mismatches++;
      end else begin
        want = expected_writes.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("strip", want.strip, got.strip);
        check_field("pixel_index", want.idx, got.idx);
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
        check_field("last", want.last, got.last);
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      cmd.mode   = s_axis_tuser;
      cmd.now_ms = s_axis_tdata[31:0];
      cmd.rnd    = s_axis_tdata[41:32];
      res = animate(strip_state, cmd);
      strip_state = res.st;
      for (int i = 0; i < res.n; i++) expected_writes.push_back(res.w[i]);
    end
  end

  // Ends a hung run: too long without a beat on either side.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, under the reset register values.
    // Pulse checks: too early, then the largest random sample, then one just
    // short of the pulse delay and one exactly at it with the smallest sample.
    queue_cmd(MODE_PULSE, 32'd0, 10'd0);
    queue_cmd(MODE_PULSE, 32'd50, 10'd1023);
    queue_cmd(MODE_PULSE, 32'd99, 10'd0);
    queue_cmd(MODE_PULSE, 32'd100, 10'd0);
    // Unused modes and a tick with nothing running.
    queue_cmd(MODE_SPARE_LO, 32'd150, 10'd1023);
    queue_cmd(MODE_SPARE_HI, 32'd150, 10'd0);
    queue_cmd(MODE_TICK, 32'd160, 10'd0);
    // Strike: a pulse check is ignored while it is held, the restore comes
    // only once more than the hold time has passed.
    queue_cmd(MODE_STRIKE, 32'd200, 10'd0);
    queue_cmd(MODE_PULSE, 32'd400, 10'd512);
    queue_cmd(MODE_TICK, 32'd500, 10'd0);
    queue_cmd(MODE_TICK, 32'd501, 10'd0);
    queue_cmd(MODE_SWING, 32'd600, 10'd0);
    queue_cmd(MODE_TICK, 32'd901, 10'd0);
    // Turn-on: a tick exactly at the frame delay is too early.
    queue_cmd(MODE_ON, 32'd1000, 10'd0);
    queue_cmd(MODE_TICK, 32'd1030, 10'd0);
    queue_cmd(MODE_TICK, 32'd1031, 10'd0);
    // Turn-off while turn-on runs: turn-on keeps priority over it and over a
    // strike.
    queue_cmd(MODE_OFF, 32'd1040, 10'd0);
    queue_cmd(MODE_TICK, 32'd1100, 10'd0);
    queue_cmd(MODE_STRIKE, 32'd1110, 10'd0);
    queue_cmd(MODE_TICK, 32'd1200, 10'd0);
    // Time stamps that wrap around the 32-bit range.
    queue_cmd(MODE_TICK, 32'hFFFF_FFF0, 10'd0);
    queue_cmd(MODE_ON, 32'hFFFF_FFF8, 10'd0);
    queue_cmd(MODE_TICK, 32'h0000_0017, 10'd0);
    now_t = 32'h0000_0017;
    wait_idle();

    // Random phases, each under its own register setting.
    for (int p = 0; p < 6; p++) begin
      configure_phase(p);
      phase_count = 0;
      while (phase_count < PHASE_CMDS) queue_random_cmd();
      // With a full backlog, hold the receiver off so the block backs up and
      // stalls its input while the sender keeps offering beats.
      if (p == 0) holds_asked++;
      wait_idle();
    end

    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
